>>> rtl/sst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sst_pkg
// Shared constants for the sorted set table: field widths, command codes
// and status codes.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int ELEM_W   = 31;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

endpackage
`default_nettype wire

>>> rtl/sst_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sst_if
// Request and response channels of the sorted set table, each with a
// valid and ready handshake.
// ----------------------------------------------------------------------------
interface sst_req_if;
    logic                                valid;
    logic                                ready;
    logic [sst_pkg::CMD_W-1:0]           cmd;
    logic signed [sst_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sst_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [sst_pkg::STATUS_W-1:0]     status;
    logic                             found;
    logic [sst_pkg::COUNT_W-1:0]      count;

    modport source (output valid, output status, output found, output count, input ready);
    modport sink   (input valid, input status, input found, input count, output ready);
endinterface
`default_nettype wire

>>> rtl/sst_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sst_mem
// Element store: one write port and one read port with registered read
// data.
// ----------------------------------------------------------------------------
module sst_mem #(
    parameter int DEPTH = 15,
    parameter int WIDTH = 31,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/sorted_set_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_set_table_core
// Sorted set of distinct non-negative values with add, remove and find.
// ----------------------------------------------------------------------------
// The set holds up to SLOTS-1 values in ascending order in a memory with
// one read and one write port. A request is taken only while the block is
// idle. Its response is offered at the end of at most one ascending pass
// over the memory: each cycle reads the next entry, and an insert or a
// remove moves the entries above the value by one place during that same
// pass. The store needs no clearing pass after reset. A finished response
// waits in the output register while the next request is taken; a request
// that finishes while the previous response is still held waits until it
// is accepted.
// ----------------------------------------------------------------------------
module sorted_set_table_core #(
    parameter int SLOTS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sst_req_if.sink   i_req,
    sst_rsp_if.source o_rsp
);

    localparam int CAP = SLOTS - 1;
    localparam int CW  = $clog2(SLOTS);
    localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAP);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} t_state;

    t_state                          r_state, n_state;
    logic [sst_pkg::CMD_W-1:0]       r_cmd, n_cmd;
    logic [sst_pkg::ELEM_W-1:0]      r_val, n_val;
    logic [sst_pkg::ELEM_W-1:0]      r_carry, n_carry;
    logic [CW-1:0]                   r_idx, n_idx;
    logic [CW-1:0]                   r_count, n_count;
    logic                            r_shift, n_shift;
    logic [sst_pkg::STATUS_W-1:0]    r_status, n_status;
    logic                            r_found, n_found;
    logic                            r_ovalid, n_ovalid;
    logic [sst_pkg::STATUS_W-1:0]    r_ostatus, n_ostatus;
    logic                            r_ofound, n_ofound;
    logic [sst_pkg::COUNT_W-1:0]     r_ocount, n_ocount;

    logic                            w_we;
    logic [AW-1:0]                   w_waddr;
    logic [sst_pkg::ELEM_W-1:0]      w_wdata;
    logic                            w_re;
    logic [AW-1:0]                   w_raddr;
    logic [sst_pkg::ELEM_W-1:0]      w_rdata;
    logic [CW-1:0]                   w_idx_inc;
    logic                            w_last;
    logic                            w_neg;
    logic [CW+sst_pkg::COUNT_W-1:0]  w_cnt_ext;

    sst_mem #(
        .DEPTH (CAP),
        .WIDTH (sst_pkg::ELEM_W),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_idx_inc = r_idx + ONE_C;
    assign w_last    = (w_idx_inc == r_count);
    assign w_neg     = i_req.value[sst_pkg::VALUE_W-1];
    assign w_cnt_ext = {{sst_pkg::COUNT_W{1'b0}}, r_count};

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_ovalid;
    assign o_rsp.status = r_ostatus;
    assign o_rsp.found  = r_ofound;
    assign o_rsp.count  = r_ocount;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_val     = r_val;
        n_carry   = r_carry;
        n_idx     = r_idx;
        n_count   = r_count;
        n_shift   = r_shift;
        n_status  = r_status;
        n_found   = r_found;
        n_ovalid  = r_ovalid;
        n_ostatus = r_ostatus;
        n_ofound  = r_ofound;
        n_ocount  = r_ocount;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = r_carry;
        w_re      = 1'b0;
        w_raddr   = '0;

        if (o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd    = i_req.cmd;
                    n_val    = i_req.value[sst_pkg::ELEM_W-1:0];
                    n_idx    = '0;
                    n_shift  = 1'b0;
                    n_found  = 1'b0;
                    n_status = sst_pkg::ST_REJECT;
                    n_state  = S_DONE;
                    case (i_req.cmd)
                        sst_pkg::CMD_ADD: begin
                            if (!w_neg && r_count < CAP_C) begin
                                if (r_count == '0) begin
                                    w_we     = 1'b1;
                                    w_wdata  = i_req.value[sst_pkg::ELEM_W-1:0];
                                    n_count  = ONE_C;
                                    n_status = sst_pkg::ST_OK;
                                end else begin
                                    w_re    = 1'b1;
                                    n_state = S_WALK;
                                end
                            end
                        end
                        sst_pkg::CMD_REMOVE: begin
                            if (!w_neg && r_count != '0) begin
                                w_re    = 1'b1;
                                n_state = S_WALK;
                            end
                        end
                        sst_pkg::CMD_FIND: begin
                            n_status = sst_pkg::ST_OK;
                            if (!w_neg && r_count != '0) begin
                                w_re    = 1'b1;
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_status = sst_pkg::ST_REJECT;
                        end
                    endcase
                end
            end

            S_WALK: begin
                w_re    = (w_idx_inc < CAP_C);
                w_raddr = w_idx_inc[AW-1:0];
                n_idx   = w_idx_inc;
                if (!r_shift) begin
                    if (w_rdata < r_val) begin
                        if (w_last) begin
                            n_state = S_DONE;
                            case (r_cmd)
                                sst_pkg::CMD_ADD: begin
                                    w_we     = 1'b1;
                                    w_waddr  = r_count[AW-1:0];
                                    w_wdata  = r_val;
                                    n_count  = r_count + ONE_C;
                                    n_status = sst_pkg::ST_OK;
                                end
                                sst_pkg::CMD_REMOVE: begin
                                    n_status = (r_count == CAP_C) ? sst_pkg::ST_REJECT
                                                                  : sst_pkg::ST_NOT_FOUND;
                                end
                                default: begin
                                    n_status = sst_pkg::ST_OK;
                                end
                            endcase
                        end
                    end else if (w_rdata == r_val) begin
                        case (r_cmd)
                            sst_pkg::CMD_ADD: begin
                                n_status = sst_pkg::ST_REJECT;
                                n_state  = S_DONE;
                            end
                            sst_pkg::CMD_REMOVE: begin
                                if (w_last) begin
                                    n_count  = r_count - ONE_C;
                                    n_status = sst_pkg::ST_OK;
                                    n_state  = S_DONE;
                                end else begin
                                    n_shift = 1'b1;
                                end
                            end
                            default: begin
                                n_found  = 1'b1;
                                n_status = sst_pkg::ST_OK;
                                n_state  = S_DONE;
                            end
                        endcase
                    end else begin
                        case (r_cmd)
                            sst_pkg::CMD_ADD: begin
                                w_we    = 1'b1;
                                w_waddr = r_idx[AW-1:0];
                                w_wdata = r_val;
                                n_carry = w_rdata;
                                n_shift = 1'b1;
                            end
                            sst_pkg::CMD_REMOVE: begin
                                n_status = sst_pkg::ST_NOT_FOUND;
                                n_state  = S_DONE;
                            end
                            default: begin
                                n_status = sst_pkg::ST_OK;
                                n_state  = S_DONE;
                            end
                        endcase
                    end
                end else begin
                    case (r_cmd)
                        sst_pkg::CMD_ADD: begin
                            w_we    = 1'b1;
                            w_waddr = r_idx[AW-1:0];
                            w_wdata = r_carry;
                            n_carry = w_rdata;
                            if (r_idx == r_count) begin
                                n_count  = r_count + ONE_C;
                                n_status = sst_pkg::ST_OK;
                                n_state  = S_DONE;
                            end
                        end
                        sst_pkg::CMD_REMOVE: begin
                            w_we    = 1'b1;
                            w_waddr = AW'(r_idx - ONE_C);
                            w_wdata = w_rdata;
                            if (w_last) begin
                                n_count  = r_count - ONE_C;
                                n_status = sst_pkg::ST_OK;
                                n_state  = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_ofound  = r_found;
                    n_ocount  = w_cnt_ext[sst_pkg::COUNT_W-1:0];
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_shift  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_shift  <= n_shift;
            r_ovalid <= n_ovalid;
        end
        r_cmd     <= n_cmd;
        r_val     <= n_val;
        r_carry   <= n_carry;
        r_idx     <= n_idx;
        r_status  <= n_status;
        r_found   <= n_found;
        r_ostatus <= n_ostatus;
        r_ofound  <= n_ofound;
        r_ocount  <= n_ocount;
    end

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("element count exceeds capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == CW'($past(r_count) + ONE_C) || r_count == CW'($past(r_count) - ONE_C)))
        else $error("element count changed by more than one");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_idx <= r_count))
        else $error("walk index passed the element count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ovalid && !o_rsp.ready) |=> (r_state == S_DONE))
        else $error("response loaded over a pending response");
`endif

endmodule
`default_nettype wire
